// ===== hdl/cms_pkg.sv =====
// cms_pkg: shared types and constants for the can message segmenter
// no dependencies; used by the channel interfaces and all modules
package cms_pkg;

  localparam logic        KIND_HEADER = 1'b0;
  localparam logic        KIND_DATA   = 1'b1;

  localparam logic [10:0] LIMIT_CAP   = 11'd1783;
  localparam logic [10:0] SINGLE_MAX  = 11'd8;

  // ceil((len - 5) / 7) = floor((len + 1) * RECIP_7 >> RECIP_SHIFT) for len up to 1783
  localparam logic [11:0] RECIP_7     = 12'd2341;
  localparam int          RECIP_SHIFT = 14;

  localparam logic [1:0]  ORDER_SINGLE = 2'd0;
  localparam logic [1:0]  ORDER_FIRST  = 2'd1;
  localparam logic [1:0]  ORDER_MIDDLE = 2'd2;
  localparam logic [1:0]  ORDER_LAST   = 2'd3;

  localparam logic [3:0]  FRAME_FULL   = 4'd8;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SINGLE,
    PH_FIRST,
    PH_REST
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] msg_length;
    logic [4:0]  node_number;
    logic [3:0]  frame_kind;
    logic [7:0]  payload_type;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic        error;
    logic [10:0] std_id;
    logic [3:0]  dlc;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
    logic        final_frame;
  } frame_t;

endpackage

// ===== hdl/cms_item_if.sv =====
// cms_item_if: valid/ready channel carrying one input item
// depends on cms_pkg
interface cms_item_if import cms_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cms_frame_if.sv =====
// cms_frame_if: valid/ready channel carrying one result frame
// depends on cms_pkg
interface cms_frame_if import cms_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cms_core.sv =====
// cms_core: segmenter state and per-item frame building logic
// depends on cms_pkg
module cms_core import cms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  item_t       item,
  input  logic [10:0] max_length,
  output logic        emit,
  output frame_t      frame
);

  phase_t      phase, phase_next;
  logic [10:0] bytes_left, bytes_left_next;
  logic [7:0]  frame_number, frame_number_next;
  logic [7:0]  frame_total, frame_total_next;
  logic [7:0]  frame_bytes [8];
  logic [7:0]  frame_bytes_next [8];
  logic [3:0]  fill_count, fill_count_next;
  logic [4:0]  held_node, held_node_next;
  logic [3:0]  held_type, held_type_next;

  logic        is_header;
  logic [10:0] len;
  logic [10:0] limit;
  logic [10:0] len_plus;
  logic [22:0] prod;
  logic [7:0]  total;
  logic [3:0]  fill_inc;
  logic [10:0] left_dec;
  logic [7:0]  number_inc;
  logic [7:0]  fb_wr [8];
  logic [7:0]  masked [8];

  logic        err;
  logic [1:0]  code;
  logic [3:0]  dlc;
  logic        last;

  assign is_header  = item.kind == KIND_HEADER;
  assign len        = item.msg_length;
  assign limit      = (max_length > LIMIT_CAP) ? LIMIT_CAP : max_length;
  assign len_plus   = len + 11'd1;
  assign prod       = 23'(len_plus) * 23'(RECIP_7);
  assign total      = prod[RECIP_SHIFT +: 8] + 8'd1;
  assign fill_inc   = fill_count + 4'd1;
  assign left_dec   = bytes_left - 11'd1;
  assign number_inc = frame_number + 8'd1;

  always_comb begin
    fb_wr = frame_bytes;
    fb_wr[fill_count[2:0]] = item.payload_byte;
  end

  // next state
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    frame_number_next = frame_number;
    frame_total_next  = frame_total;
    frame_bytes_next  = frame_bytes;
    fill_count_next   = fill_count;
    held_node_next    = held_node;
    held_type_next    = held_type;
    if (fire) begin
      if (is_header) begin
        held_node_next = item.node_number;
        held_type_next = item.frame_kind;
        for (int k = 0; k < 8; k++) frame_bytes_next[k] = 8'd0;
        fill_count_next = 4'd0;
        if (len <= SINGLE_MAX) begin
          bytes_left_next = len;
          phase_next      = (len == 11'd0) ? PH_IDLE : PH_SINGLE;
        end else if (len > limit) begin
          bytes_left_next = 11'd0;
          phase_next      = PH_IDLE;
        end else begin
          frame_total_next    = total;
          frame_number_next   = 8'd1;
          frame_bytes_next[0] = 8'd1;
          frame_bytes_next[1] = total;
          frame_bytes_next[2] = item.payload_type;
          fill_count_next     = 4'd3;
          bytes_left_next     = len;
          phase_next          = PH_FIRST;
        end
      end else if (phase != PH_IDLE) begin
        frame_bytes_next = fb_wr;
        fill_count_next  = fill_inc;
        bytes_left_next  = left_dec;
        unique case (phase)
          PH_SINGLE: begin
            if (left_dec == 11'd0) phase_next = PH_IDLE;
          end
          PH_FIRST: begin
            if (fill_inc >= FRAME_FULL) begin
              frame_number_next = number_inc;
              for (int k = 0; k < 8; k++) frame_bytes_next[k] = 8'd0;
              frame_bytes_next[0] = number_inc;
              fill_count_next     = 4'd1;
              phase_next          = PH_REST;
            end
          end
          PH_REST: begin
            if (left_dec == 11'd0) begin
              phase_next = PH_IDLE;
            end else if (fill_inc >= FRAME_FULL) begin
              frame_number_next = number_inc;
              for (int k = 0; k < 8; k++) frame_bytes_next[k] = 8'd0;
              frame_bytes_next[0] = number_inc;
              fill_count_next     = 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result
  always_comb begin
    emit = 1'b0;
    err  = 1'b0;
    code = ORDER_SINGLE;
    dlc  = 4'd0;
    last = 1'b0;
    if (fire) begin
      if (is_header) begin
        if (len == 11'd0) begin
          emit = 1'b1;
          last = 1'b1;
        end else if (len > SINGLE_MAX && len > limit) begin
          emit = 1'b1;
          err  = 1'b1;
        end
      end else begin
        unique case (phase)
          PH_SINGLE: begin
            if (left_dec == 11'd0) begin
              emit = 1'b1;
              dlc  = fill_inc;
              last = 1'b1;
            end
          end
          PH_FIRST: begin
            if (fill_inc >= FRAME_FULL) begin
              emit = 1'b1;
              code = ORDER_FIRST;
              dlc  = FRAME_FULL;
            end
          end
          PH_REST: begin
            if (left_dec == 11'd0) begin
              emit = 1'b1;
              code = ORDER_LAST;
              dlc  = fill_inc;
              last = 1'b1;
            end else if (fill_inc >= FRAME_FULL) begin
              emit = 1'b1;
              code = ORDER_MIDDLE;
              dlc  = FRAME_FULL;
            end
          end
          default: begin
          end
        endcase
      end
    end

    for (int k = 0; k < 8; k++) begin
      masked[k] = (4'(k) < dlc && !is_header) ? fb_wr[k] : 8'd0;
    end

    if (err) begin
      frame       = '0;
      frame.error = 1'b1;
    end else begin
      frame.error       = 1'b0;
      frame.std_id      = is_header ? {item.frame_kind, item.node_number, code}
                                    : {held_type, held_node, code};
      frame.dlc         = dlc;
      frame.byte0       = masked[0];
      frame.byte1       = masked[1];
      frame.byte2       = masked[2];
      frame.byte3       = masked[3];
      frame.byte4       = masked[4];
      frame.byte5       = masked[5];
      frame.byte6       = masked[6];
      frame.byte7       = masked[7];
      frame.final_frame = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bytes_left   <= 11'd0;
      frame_number <= 8'd0;
      frame_total  <= 8'd0;
      for (int k = 0; k < 8; k++) frame_bytes[k] <= 8'd0;
      fill_count   <= 4'd0;
      held_node    <= 5'd0;
      held_type    <= 4'd0;
    end else begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      frame_number <= frame_number_next;
      frame_total  <= frame_total_next;
      frame_bytes  <= frame_bytes_next;
      fill_count   <= fill_count_next;
      held_node    <= held_node_next;
      held_type    <= held_type_next;
    end
  end

endmodule

// ===== hdl/cms_out_buf.sv =====
// cms_out_buf: result register with a skid stage in front of the output channel
// depends on cms_pkg and cms_frame_if
module cms_out_buf import cms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_t      push_data,
  output logic        space,
  cms_frame_if.source out_ch
);

  logic   out_valid;
  frame_t out_data;
  logic   skid_valid;
  frame_t skid_data;

  assign space        = !skid_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ch.ready) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_ch.ready) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/can_message_segmenter_top.sv =====
// can message segmenter: one input item in, at most one CAN frame out per item
// path: items are registered in s1_item, frames in the result register (or skid)
// throughput: one item per cycle unless out_ch stalls, set by s1 and result/skid pair
// reset: synchronous, clears phase, counters and held header; max_length returns to 1783
// depends on cms_pkg, cms_item_if, cms_frame_if, cms_core, cms_out_buf
module can_message_segmenter_top import cms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cms_item_if.sink    in_ch,
  cms_frame_if.source out_ch,
  input  logic        cfg_write_en,
  input  logic [10:0] cfg_write_data
);

  logic [10:0] max_length;
  logic        s1_valid;
  item_t       s1_item;
  logic        space;
  logic        fire;
  logic        emit;
  frame_t      frame;

  assign fire        = s1_valid && space;
  assign in_ch.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= LIMIT_CAP;
    end else if (cfg_write_en) begin
      max_length <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item <= in_ch.data;
    end
  end

  cms_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (s1_item),
    .max_length (max_length),
    .emit       (emit),
    .frame      (frame)
  );

  cms_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (frame),
    .space     (space),
    .out_ch    (out_ch)
  );

endmodule
